### src/srfp_pkg.sv
// Shared types and constants for the sensor response frame parser.
// No dependencies; imported by srfp_front, srfp_queue and the top level.
package srfp_pkg;

    // Link framing bytes
    localparam logic [7:0] SYNC_BYTE0 = 8'hEF;
    localparam logic [7:0] SYNC_BYTE1 = 8'h01;
    localparam logic [7:0] KIND_ACK   = 8'h07;
    localparam logic [7:0] KIND_DATA  = 8'h02;

    // Configuration register indexes
    localparam logic CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic CFG_MAX_LENGTH     = 1'b1;

    // Configuration reset values
    localparam logic [31:0] DEVICE_ADDRESS_RST = 32'hFFFF_FFFF;
    localparam logic [15:0] MAX_LENGTH_RST     = 16'd87;

    // Minimum legal length field (trailer only)
    localparam logic [15:0] MIN_LENGTH = 16'd2;

    // Result kind codes
    localparam logic RES_PAYLOAD = 1'b0;
    localparam logic RES_STATUS  = 1'b1;

    // Frame kind codes
    localparam logic [1:0] FKIND_ACK   = 2'd0;
    localparam logic [1:0] FKIND_DATA  = 2'd1;
    localparam logic [1:0] FKIND_OTHER = 2'd2;

    // Frame status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_ADDR  = 3'd1;
    localparam logic [2:0] ST_SHORT     = 3'd2;
    localparam logic [2:0] ST_TOO_LONG  = 3'd3;
    localparam logic [2:0] ST_BAD_SUM   = 3'd4;
    localparam logic [2:0] ST_EMPTY_ACK = 3'd5;

    // Default depth of the result queue
    localparam int QUEUE_DEPTH = 4;

    // One result item as it travels from the parser to the output side
    typedef struct packed {
        logic       result_kind;
        logic [7:0] payload_byte;
        logic [1:0] frame_kind;
        logic [2:0] frame_status;
        logic [7:0] confirm_code;
    } t_result;

endpackage

### src/sensor_response_frame_parser.sv
// Top level of the sensor response frame parser.
// Depends on srfp_pkg, srfp_front (parser) and srfp_queue (result buffer).
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  input    | i_valid / o_ready    | i_rx_byte, i_restart
//  output   | o_valid / i_ready    | o_result_kind, o_payload_byte, ...
//  config   | i_cfg_wr_en          | i_cfg_idx, i_cfg_data
//
// One input beat per cycle while the queue has space; each beat yields zero or one result beat.
// A result is written into the result queue when its input beat is taken and leaves in order.
// The input stalls only when the result queue (QueueDepth entries) is full.
// Reset is synchronous, active low; it restores both config registers
// and sends the parser back to sync hunting with an empty queue.
module sensor_response_frame_parser #(
    parameter int QueueDepth = srfp_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_restart,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_result_kind,
    output logic [7:0]  o_payload_byte,
    output logic [1:0]  o_frame_kind,
    output logic [2:0]  o_frame_status,
    output logic [7:0]  o_confirm_code,
    output logic        o_frame_end
);
    import srfp_pkg::*;

    logic    push;
    logic    space;
    t_result front_result;
    t_result head;

    // Parse bytes into result records
    srfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .i_rx_byte   (i_rx_byte),
        .i_restart   (i_restart),
        .i_space     (space),
        .o_ready     (o_ready),
        .o_push      (push),
        .o_result    (front_result)
    );

    // Buffer results toward the output channel
    srfp_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (front_result),
        .o_space  (space),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (head)
    );

    // Unpack the head record onto the output ports
    assign o_result_kind  = head.result_kind;
    assign o_payload_byte = head.payload_byte;
    assign o_frame_kind   = head.frame_kind;
    assign o_frame_status = head.frame_status;
    assign o_confirm_code = head.confirm_code;
    assign o_frame_end    = (head.result_kind == RES_STATUS);

endmodule

### src/srfp_front.sv
// Byte-level frame parser: sync hunt, header checks, checksum, result build.
// Depends on srfp_pkg; pushes results into srfp_queue.
module srfp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_valid,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_restart,
    input  logic              i_space,
    output logic              o_ready,
    output logic              o_push,
    output srfp_pkg::t_result o_result
);
    import srfp_pkg::*;

    localparam logic [3:0] PH_SYNC0 = 4'd0;
    localparam logic [3:0] PH_SYNC1 = 4'd1;
    localparam logic [3:0] PH_ADDR  = 4'd2;
    localparam logic [3:0] PH_KIND  = 4'd3;
    localparam logic [3:0] PH_LENH  = 4'd4;
    localparam logic [3:0] PH_LENL  = 4'd5;
    localparam logic [3:0] PH_PAY   = 4'd6;
    localparam logic [3:0] PH_SUMH  = 4'd7;
    localparam logic [3:0] PH_SUML  = 4'd8;

    logic [31:0] r_device_address;
    logic [15:0] r_max_length;

    logic [3:0]  r_phase, n_phase;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_kind, n_kind;
    logic [15:0] r_len, n_len;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_trail_hi, n_trail_hi;
    logic        r_addr_ok, n_addr_ok;
    logic [7:0]  r_confirm, n_confirm;

    // Frame state as seen by this beat, after an optional restart
    logic [3:0]  s_phase;
    logic [15:0] s_count;
    logic [7:0]  s_kind;
    logic [15:0] s_len;
    logic [15:0] s_sum;
    logic [7:0]  s_trail_hi;
    logic        s_addr_ok;
    logic [7:0]  s_confirm;

    logic        accept;
    logic        emit;
    logic        emit_status;
    logic [2:0]  status;
    logic [7:0]  status_confirm;
    logic [7:0]  want_byte;
    logic [15:0] full_len;
    logic [15:0] sum_add;
    logic [15:0] count_inc;
    logic [15:0] pay_len;
    logic [1:0]  kind_code;

    assign o_ready = i_space;
    assign accept  = i_valid && i_space;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= DEVICE_ADDRESS_RST;
            r_max_length     <= MAX_LENGTH_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_DEVICE_ADDRESS: r_device_address <= i_cfg_data;
                CFG_MAX_LENGTH:     r_max_length     <= i_cfg_data[15:0];
                default:            r_max_length     <= r_max_length;
            endcase
        end
    end

    // Drop the partial frame on restart
    always_comb begin
        if (i_restart) begin
            s_phase    = PH_SYNC0;
            s_count    = '0;
            s_kind     = '0;
            s_len      = '0;
            s_sum      = '0;
            s_trail_hi = '0;
            s_addr_ok  = 1'b1;
            s_confirm  = '0;
        end else begin
            s_phase    = r_phase;
            s_count    = r_count;
            s_kind     = r_kind;
            s_len      = r_len;
            s_sum      = r_sum;
            s_trail_hi = r_trail_hi;
            s_addr_ok  = r_addr_ok;
            s_confirm  = r_confirm;
        end
    end

    // Shared datapath pieces
    always_comb begin
        case (s_count[1:0])
            2'd0:    want_byte = r_device_address[31:24];
            2'd1:    want_byte = r_device_address[23:16];
            2'd2:    want_byte = r_device_address[15:8];
            default: want_byte = r_device_address[7:0];
        endcase
    end

    assign full_len  = {s_len[15:8], i_rx_byte};
    assign sum_add   = s_sum + {8'd0, i_rx_byte};
    assign count_inc = s_count + 16'd1;
    assign pay_len   = s_len - MIN_LENGTH;

    always_comb begin
        if (s_kind == KIND_ACK) begin
            kind_code = FKIND_ACK;
        end else if (s_kind == KIND_DATA) begin
            kind_code = FKIND_DATA;
        end else begin
            kind_code = FKIND_OTHER;
        end
    end

    // Parser step
    always_comb begin
        n_phase        = s_phase;
        n_count        = s_count;
        n_kind         = s_kind;
        n_len          = s_len;
        n_sum          = s_sum;
        n_trail_hi     = s_trail_hi;
        n_addr_ok      = s_addr_ok;
        n_confirm      = s_confirm;
        emit           = 1'b0;
        emit_status    = 1'b0;
        status         = ST_OK;
        status_confirm = 8'd0;

        case (s_phase)
            PH_SYNC0: begin
                if (i_rx_byte == SYNC_BYTE0) n_phase = PH_SYNC1;
            end
            PH_SYNC1: begin
                if (i_rx_byte == SYNC_BYTE1) begin
                    n_phase   = PH_ADDR;
                    n_count   = '0;
                    n_addr_ok = 1'b1;
                end else if (i_rx_byte != SYNC_BYTE0) begin
                    n_phase = PH_SYNC0;
                end
            end
            PH_ADDR: begin
                if (i_rx_byte != want_byte) n_addr_ok = 1'b0;
                n_count = count_inc;
                if (count_inc >= 16'd4) n_phase = PH_KIND;
            end
            PH_KIND: begin
                n_kind  = i_rx_byte;
                n_sum   = {8'd0, i_rx_byte};
                n_phase = PH_LENH;
            end
            PH_LENH: begin
                n_len   = {i_rx_byte, 8'd0};
                n_sum   = sum_add;
                n_phase = PH_LENL;
            end
            PH_LENL: begin
                n_len = full_len;
                n_sum = sum_add;
                if (!s_addr_ok) begin
                    emit_status = 1'b1;
                    status      = ST_BAD_ADDR;
                end else if (full_len < MIN_LENGTH) begin
                    emit_status = 1'b1;
                    status      = ST_SHORT;
                end else if (full_len > r_max_length) begin
                    emit_status = 1'b1;
                    status      = ST_TOO_LONG;
                end else begin
                    n_count = '0;
                    n_phase = (full_len == MIN_LENGTH) ? PH_SUMH : PH_PAY;
                end
            end
            PH_PAY: begin
                n_sum   = sum_add;
                n_count = count_inc;
                if (count_inc >= pay_len) n_phase = PH_SUMH;
                if (s_kind == KIND_ACK) begin
                    if (s_count == 16'd0) n_confirm = i_rx_byte;
                    else                  emit      = 1'b1;
                end else if (s_kind == KIND_DATA) begin
                    emit = 1'b1;
                end
            end
            PH_SUMH: begin
                n_trail_hi = i_rx_byte;
                n_phase    = PH_SUML;
            end
            PH_SUML: begin
                emit_status = 1'b1;
                if ({s_trail_hi, i_rx_byte} != s_sum) begin
                    status = ST_BAD_SUM;
                end else if (s_kind == KIND_ACK && pay_len == 16'd0) begin
                    status = ST_EMPTY_ACK;
                end else begin
                    status         = ST_OK;
                    status_confirm = (s_kind == KIND_ACK) ? s_confirm : 8'd0;
                end
            end
            default: begin
                n_phase = PH_SYNC0;
            end
        endcase

        // A status, or an invalid phase, closes the frame and resumes hunting
        if (emit_status || (s_phase > PH_SUML)) begin
            n_phase    = PH_SYNC0;
            n_count    = '0;
            n_kind     = '0;
            n_len      = '0;
            n_sum      = '0;
            n_trail_hi = '0;
            n_addr_ok  = 1'b1;
            n_confirm  = '0;
        end
    end

    // Build the result record
    always_comb begin
        o_result.result_kind  = emit_status ? RES_STATUS : RES_PAYLOAD;
        o_result.payload_byte = emit_status ? 8'd0 : i_rx_byte;
        o_result.frame_kind   = kind_code;
        o_result.frame_status = emit_status ? status : ST_OK;
        o_result.confirm_code = status_confirm;
    end

    assign o_push = accept && (emit || emit_status);

    // Advance frame state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SYNC0;
            r_count    <= '0;
            r_kind     <= '0;
            r_len      <= '0;
            r_sum      <= '0;
            r_trail_hi <= '0;
            r_addr_ok  <= 1'b1;
            r_confirm  <= '0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_kind     <= n_kind;
            r_len      <= n_len;
            r_sum      <= n_sum;
            r_trail_hi <= n_trail_hi;
            r_addr_ok  <= n_addr_ok;
            r_confirm  <= n_confirm;
        end
    end

endmodule

### src/srfp_queue.sv
// Short result queue between the parser and the output channel.
// Depends on srfp_pkg for the result record type.
module srfp_queue #(
    parameter int Depth = srfp_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  srfp_pkg::t_result i_result,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output srfp_pkg::t_result o_result
);
    import srfp_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCount = CntW'(Depth);

    t_result         r_store [Depth];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;
    logic            pop;

    assign o_space  = (r_count != FullCount);
    assign o_valid  = (r_count != '0);
    assign o_result = r_store[r_rd_ptr];
    assign pop      = o_valid && i_ready;

    // Wrap pointers and track fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        if (pop)    n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        if (i_push && !pop)      n_count = r_count + 1'b1;
        else if (pop && !i_push) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Write the entry at the tail
    always_ff @(posedge i_clk) begin
        if (i_push) r_store[r_wr_ptr] <= i_result;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FullCount)
        else $error("result queue count above depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != FullCount))
        else $error("push into full result queue");

    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("result queue count did not grow on push");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty result queue with pointers apart");
`endif

endmodule

### tb/sv/tb_sensor_response_frame_parser.sv
`timescale 1ns / 100ps
// Testbench for sensor_response_frame_parser: directed frames, register extremes,
// backpressure and random link traffic, checked beat by beat against a frame tracker.
// Depends on srfp_pkg and the sensor_response_frame_parser RTL.
module tb_sensor_response_frame_parser;
    import srfp_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int RANDOM_BEATS  = 50;
    localparam logic [7:0] KIND_MISC = 8'h5A;

    typedef enum logic [3:0] {
        SEEK_EF, SEEK_01, TAKE_ADDR, TAKE_KIND, TAKE_LEN_HI, TAKE_LEN_LO,
        TAKE_PAYLOAD, TAKE_SUM_HI, TAKE_SUM_LO
    } t_link_phase;

    typedef struct packed {
        t_result res;
        logic    last;
    } t_frame_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_rx_byte;
    logic        i_restart;
    logic        o_valid;
    logic        i_ready;
    logic        o_result_kind;
    logic [7:0]  o_payload_byte;
    logic [1:0]  o_frame_kind;
    logic [2:0]  o_frame_status;
    logic [7:0]  o_confirm_code;
    logic        o_frame_end;

    // Frame tracker state and its copy of the registers
    t_link_phase fr_phase;
    logic [15:0] fr_count;
    logic [7:0]  fr_kind;
    logic [15:0] fr_length;
    logic [15:0] fr_sum;
    logic [7:0]  fr_sum_hi;
    logic        fr_addr_ok;
    logic [7:0]  fr_confirm;
    logic [31:0] dev_addr;
    logic [15:0] len_limit;

    t_frame_result results_due[$];

    int   errors;
    int   beats_sent;
    int   payload_beats;
    int   status_beats;
    logic [7:0] status_seen;
    int   cycle_count;
    bit   tx_steady;
    bit   rx_steady;
    int   hold_req;
    int   hold_left;

    sensor_response_frame_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .i_restart      (i_restart),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_kind  (o_result_kind),
        .o_payload_byte (o_payload_byte),
        .o_frame_kind   (o_frame_kind),
        .o_frame_status (o_frame_status),
        .o_confirm_code (o_confirm_code),
        .o_frame_end    (o_frame_end)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_sensor_response_frame_parser: errors");
            $finish;
        end
    end

    // Drive result ready: random stalls, steady stretches and long hold-offs
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (rx_steady) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= 20);
        end
    end

    function automatic logic [1:0] frame_kind_code(input logic [7:0] kind);
        if (kind == KIND_ACK) return FKIND_ACK;
        if (kind == KIND_DATA) return FKIND_DATA;
        return FKIND_OTHER;
    endfunction

    task automatic reset_frame();
        fr_phase   = SEEK_EF;
        fr_count   = '0;
        fr_kind    = '0;
        fr_length  = '0;
        fr_sum     = '0;
        fr_sum_hi  = '0;
        fr_addr_ok = 1'b1;
        fr_confirm = '0;
    endtask

    task automatic close_frame(input logic [2:0] status, input logic [7:0] confirm);
        results_due.push_back({RES_STATUS, 8'h00, frame_kind_code(fr_kind), status,
                               confirm, 1'b1});
        reset_frame();
    endtask

    task automatic pass_payload(input logic [7:0] b);
        results_due.push_back({RES_PAYLOAD, b, frame_kind_code(fr_kind), ST_OK,
                               8'h00, 1'b0});
    endtask

    // Advance the frame tracker by one accepted link byte
    task automatic track_link_byte(input logic [7:0] b, input logic rs);
        logic [15:0] idx;
        int          shift;
        if (rs) reset_frame();
        case (fr_phase)
            SEEK_EF: begin
                if (b == SYNC_BYTE0) fr_phase = SEEK_01;
            end
            SEEK_01: begin
                if (b == SYNC_BYTE1) begin
                    fr_phase   = TAKE_ADDR;
                    fr_count   = '0;
                    fr_addr_ok = 1'b1;
                end else if (b != SYNC_BYTE0) begin
                    fr_phase = SEEK_EF;
                end
            end
            TAKE_ADDR: begin
                shift = 8 * (3 - int'(fr_count[1:0]));
                if (b != dev_addr[shift +: 8]) fr_addr_ok = 1'b0;
                fr_count = fr_count + 16'd1;
                if (fr_count >= 16'd4) fr_phase = TAKE_KIND;
            end
            TAKE_KIND: begin
                fr_kind  = b;
                fr_sum   = {8'h00, b};
                fr_phase = TAKE_LEN_HI;
            end
            TAKE_LEN_HI: begin
                fr_length = {b, 8'h00};
                fr_sum    = fr_sum + {8'h00, b};
                fr_phase  = TAKE_LEN_LO;
            end
            TAKE_LEN_LO: begin
                fr_length[7:0] = b;
                fr_sum = fr_sum + {8'h00, b};
                if (!fr_addr_ok) begin
                    close_frame(ST_BAD_ADDR, 8'h00);
                end else if (fr_length < MIN_LENGTH) begin
                    close_frame(ST_SHORT, 8'h00);
                end else if (fr_length > len_limit) begin
                    close_frame(ST_TOO_LONG, 8'h00);
                end else begin
                    fr_count = '0;
                    fr_phase = (fr_length == MIN_LENGTH) ? TAKE_SUM_HI : TAKE_PAYLOAD;
                end
            end
            TAKE_PAYLOAD: begin
                idx      = fr_count;
                fr_sum   = fr_sum + {8'h00, b};
                fr_count = fr_count + 16'd1;
                if (fr_count >= fr_length - MIN_LENGTH) fr_phase = TAKE_SUM_HI;
                // First ack byte is the confirm code, the rest pass through
                if (fr_kind == KIND_ACK) begin
                    if (idx == 16'd0) fr_confirm = b;
                    else pass_payload(b);
                end else if (fr_kind == KIND_DATA) begin
                    pass_payload(b);
                end
            end
            TAKE_SUM_HI: begin
                fr_sum_hi = b;
                fr_phase  = TAKE_SUM_LO;
            end
            TAKE_SUM_LO: begin
                if ({fr_sum_hi, b} != fr_sum) begin
                    close_frame(ST_BAD_SUM, 8'h00);
                end else if (fr_kind == KIND_ACK && fr_length == MIN_LENGTH) begin
                    close_frame(ST_EMPTY_ACK, 8'h00);
                end else begin
                    close_frame(ST_OK, (fr_kind == KIND_ACK) ? fr_confirm : 8'h00);
                end
            end
            default: reset_frame();
        endcase
    endtask

    task automatic compare_field(input string what, input logic [7:0] want,
                                 input logic [7:0] seen);
        if (seen !== want) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, what, want, seen);
        end
    endtask

    // Check each result beat against the oldest one due
    always @(posedge i_clk) begin : check_results
        t_frame_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (results_due.size() == 0) begin
                errors++;
                $display("%0t ns: result beat with none due, expected none, actual %h",
                         $time, {o_result_kind, o_payload_byte, o_frame_kind,
                                 o_frame_status, o_confirm_code, o_frame_end});
            end else begin
                want = results_due.pop_front();
                compare_field("result_kind", 8'(want.res.result_kind), 8'(o_result_kind));
                compare_field("payload_byte", want.res.payload_byte, o_payload_byte);
                compare_field("frame_kind", 8'(want.res.frame_kind), 8'(o_frame_kind));
                compare_field("frame_status", 8'(want.res.frame_status),
                              8'(o_frame_status));
                compare_field("confirm_code", want.res.confirm_code, o_confirm_code);
                compare_field("frame_end", 8'(want.last), 8'(o_frame_end));
            end
            if (o_result_kind == RES_STATUS) begin
                status_beats++;
                status_seen[o_frame_status] = 1'b1;
            end else begin
                payload_beats++;
            end
        end
    end

    // Offer one link byte, hold it until taken, then track it
    task automatic send_beat(input logic [7:0] b, input logic rs);
        @(negedge i_clk);
        if (!tx_steady) begin
            while ($urandom_range(99) < 20) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        i_restart <= rs;
        do @(posedge i_clk); while (!o_ready);
        track_link_byte(b, rs);
        beats_sent++;
    endtask

    // Send a whole frame; the body follows only when the header is accepted
    task automatic send_frame(input logic [31:0] addr, input logic [7:0] kind,
                              input logic [15:0] len, input bit bad_sum, input bit rs_first);
        logic [15:0] sum;
        logic [7:0]  b;
        send_beat(SYNC_BYTE0, rs_first);
        send_beat(SYNC_BYTE1, 1'b0);
        for (int i = 3; i >= 0; i--) send_beat(addr[8*i +: 8], 1'b0);
        send_beat(kind, 1'b0);
        send_beat(len[15:8], 1'b0);
        send_beat(len[7:0], 1'b0);
        if (addr != dev_addr || len < MIN_LENGTH || len > len_limit) return;
        sum = {8'h00, kind} + {8'h00, len[15:8]} + {8'h00, len[7:0]};
        for (int i = 0; i < int'(len) - 2; i++) begin
            b   = 8'($urandom);
            sum = sum + {8'h00, b};
            send_beat(b, 1'b0);
        end
        if (bad_sum) sum = sum ^ 16'($urandom_range(1, 65535));
        send_beat(sum[15:8], 1'b0);
        send_beat(sum[7:0], 1'b0);
    endtask

    // Send the first n bytes of a data frame and stop there
    task automatic send_fragment(input int n);
        logic [7:0] hdr [9];
        hdr = '{SYNC_BYTE0, SYNC_BYTE1, dev_addr[31:24], dev_addr[23:16],
                dev_addr[15:8], dev_addr[7:0], KIND_DATA, 8'h00, 8'd20};
        for (int i = 0; i < n; i++) send_beat((i < 9) ? hdr[i] : 8'($urandom), 1'b0);
    endtask

    // Drop valid and wait until every result has come out and the block is quiet
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        if (idx == CFG_DEVICE_ADDRESS) dev_addr = value;
        else len_limit = value[15:0];
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] addr, input logic [15:0] limit);
        drain_results();
        write_reg(CFG_DEVICE_ADDRESS, addr);
        write_reg(CFG_MAX_LENGTH, {16'($urandom), limit});
    endtask

    // Every status, both pass-through kinds, sync and restart corner cases
    task automatic test_directed_frames();
        send_frame(dev_addr, KIND_DATA, 16'd6, 1'b0, 1'b1);
        send_frame(dev_addr, KIND_ACK, 16'd5, 1'b0, 1'b0);
        send_frame(dev_addr, KIND_ACK, 16'd3, 1'b0, 1'b0);
        send_frame(dev_addr, KIND_ACK, 16'd2, 1'b0, 1'b0);
        send_frame(dev_addr, KIND_ACK, 16'd2, 1'b1, 1'b0);
        send_frame(dev_addr, KIND_MISC, 16'd4, 1'b0, 1'b0);
        send_frame(dev_addr, KIND_DATA, 16'd4, 1'b1, 1'b0);
        send_frame(dev_addr ^ 32'h0000_00FF, KIND_DATA, 16'hFFFF, 1'b0, 1'b0);
        send_frame(dev_addr, KIND_DATA, 16'd0, 1'b0, 1'b0);
        send_frame(dev_addr, KIND_ACK, 16'd1, 1'b0, 1'b0);
        send_frame(dev_addr, KIND_DATA, len_limit + 16'd1, 1'b0, 1'b0);
        // Repeated sync byte ahead of the pair
        send_beat(SYNC_BYTE0, 1'b0);
        send_frame(dev_addr, KIND_DATA, 16'd3, 1'b0, 1'b0);
        // Restart in the address and in the payload
        send_fragment(4);
        send_frame(dev_addr, KIND_ACK, 16'd4, 1'b0, 1'b1);
        send_fragment(12);
        send_frame(dev_addr, KIND_DATA, 16'd5, 1'b0, 1'b1);
        // Restart on a stray byte while hunting
        send_beat(8'hFF, 1'b1);
        send_frame(dev_addr, KIND_DATA, 16'd2, 1'b0, 1'b0);
    endtask

    // Smallest and largest register settings
    task automatic test_register_extremes();
        set_config(32'h0000_0000, MIN_LENGTH);
        send_frame(dev_addr, KIND_DATA, 16'd2, 1'b0, 1'b0);
        send_frame(dev_addr, KIND_ACK, 16'd2, 1'b0, 1'b0);
        send_frame(dev_addr, KIND_MISC, 16'd2, 1'b0, 1'b0);
        send_frame(dev_addr, KIND_DATA, 16'd3, 1'b0, 1'b0);
        send_frame(32'hFFFF_FFFF, KIND_DATA, 16'd2, 1'b0, 1'b0);
        set_config($urandom, 16'hFFFF);
        send_frame(dev_addr, KIND_DATA, 16'd302, 1'b0, 1'b0);
        send_frame(dev_addr, KIND_ACK, 16'd10, 1'b0, 1'b0);
        // Largest length is taken; cut it short with a restart
        send_beat(SYNC_BYTE0, 1'b0);
        send_beat(SYNC_BYTE1, 1'b0);
        for (int i = 3; i >= 0; i--) send_beat(dev_addr[8*i +: 8], 1'b0);
        send_beat(KIND_DATA, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'hFF, 1'b0);
        repeat (6) send_beat(8'($urandom), 1'b0);
        send_frame(dev_addr, KIND_ACK, 16'd4, 1'b0, 1'b1);
        set_config($urandom, MAX_LENGTH_RST);
    endtask

    // Fill the result queue with a long hold-off, then a stretch with no idling
    task automatic test_backpressure();
        tx_steady = 1'b1;
        hold_req  = 80;
        send_frame(dev_addr, KIND_DATA, 16'd42, 1'b0, 1'b0);
        tx_steady = 1'b0;
        drain_results();
        hold_req = 60;
        send_frame(dev_addr, KIND_ACK, 16'd30, 1'b0, 1'b0);
        drain_results();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        for (int i = 0; i < 8; i++) send_frame(dev_addr, KIND_DATA, 16'd12, 1'b0, 1'b0);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Mostly well-formed frames with random content; the rest is broken traffic
    task automatic random_phase();
        int   start;
        int   r;
        int   cap;
        int   plen;
        int   l;
        bit   resync;
        logic [7:0] kind;
        start  = beats_sent;
        resync = 1'b0;
        while (beats_sent - start < RANDOM_BEATS) begin
            r    = $urandom_range(99);
            cap  = int'(len_limit) - 2;
            if (cap > 30) cap = 30;
            plen = ($urandom_range(9) == 0) ? cap : $urandom_range(cap);
            case ($urandom_range(9))
                0, 1, 2, 3: kind = KIND_DATA;
                4, 5, 6:    kind = KIND_ACK;
                default:    kind = 8'($urandom);
            endcase
            if (r < 70) begin
                send_frame(dev_addr, kind, 16'(plen + 2), $urandom_range(9) == 0, resync);
            end else if (r < 78) begin
                send_frame(dev_addr ^ (32'd1 << $urandom_range(31)), kind,
                           16'(plen + 2), 1'b0, resync);
            end else if (r < 85) begin
                l = int'(len_limit) + int'($urandom_range(1, 3));
                if (l > 65535 || $urandom_range(1) == 0) l = $urandom_range(1);
                send_frame(dev_addr, kind, 16'(l), 1'b0, resync);
            end else if (r < 93) begin
                send_fragment($urandom_range(1, 16));
                resync = 1'b1;
                continue;
            end else begin
                for (int i = $urandom_range(1, 6); i > 0; i--)
                    send_beat(8'($urandom), $urandom_range(7) == 0);
                resync = $urandom_range(1);
                continue;
            end
            resync = 1'b0;
        end
    endtask

    task automatic test_random_frames();
        set_config($urandom, MAX_LENGTH_RST);
        random_phase();
        set_config(32'h0000_0000, MIN_LENGTH);
        random_phase();
        set_config(32'hFFFF_FFFF, 16'hFFFF);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        random_phase();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        set_config($urandom, 16'($urandom_range(3, 40)));
        random_phase();
        set_config($urandom, 16'd20);
        random_phase();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_idx   = CFG_DEVICE_ADDRESS;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_rx_byte   = '0;
        i_restart   = 1'b0;
        i_ready     = 1'b0;
        errors        = 0;
        beats_sent    = 0;
        payload_beats = 0;
        status_beats  = 0;
        status_seen   = '0;
        cycle_count   = 0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        hold_req      = 0;
        hold_left     = 0;
        dev_addr      = DEVICE_ADDRESS_RST;
        len_limit     = MAX_LENGTH_RST;
        reset_frame();

        // Hold reset, release it away from the active edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_frames();
        test_register_extremes();
        test_backpressure();
        test_random_frames();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (results_due.size() != 0) begin
            errors++;
            $display("%0t ns: results left over, expected 0, actual %0d",
                     $time, results_due.size());
        end

        $display("Sent %0d link bytes across several register settings; saw %0d payload and",
                 beats_sent, payload_beats);
        $display("%0d status beats, status codes seen (bit per code) %b",
                 status_beats, status_seen[5:0]);
        if (errors == 0) begin
            $display("tb_sensor_response_frame_parser: clean");
        end else begin
            $display("tb_sensor_response_frame_parser: errors");
        end
        $finish;
    end

endmodule

### files.f
src/srfp_pkg.sv
src/srfp_front.sv
src/srfp_queue.sv
src/sensor_response_frame_parser.sv
tb/sv/tb_sensor_response_frame_parser.sv
